[design/palist_pkg.sv]
// shared constants, status and operation codes and the memory request type
// for the positional array list engine; depends on nothing
`timescale 1ns / 1ps

package palist_pkg;

	// list capacity and cap on search results per request
	localparam int DEPTH       = 32;
	localparam int MAX_RESULTS = 32;

	// field widths
	localparam int KW  = 2;
	localparam int PW  = 6;
	localparam int VW  = 32;
	localparam int SW  = 3;
	localparam int FW  = 7;
	localparam int NCW = 7;

	// derived widths
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);
	localparam int NW = $clog2(MAX_RESULTS + 1);
	localparam int CW = ((LW > PW) ? LW : PW) + 1;

	// operation codes
	localparam logic [KW-1:0] K_INSERT = 2'd0;
	localparam logic [KW-1:0] K_DELETE = 2'd1;
	localparam logic [KW-1:0] K_READ   = 2'd2;
	localparam logic [KW-1:0] K_SEARCH = 2'd3;

	// status codes
	localparam logic [SW-1:0] ST_OK       = 3'd0;
	localparam logic [SW-1:0] ST_EMPTY    = 3'd1;
	localparam logic [SW-1:0] ST_BADPOS   = 3'd2;
	localparam logic [SW-1:0] ST_FULL     = 3'd3;
	localparam logic [SW-1:0] ST_NOTFOUND = 3'd4;

	// memory traffic from the sequencer for the current cycle
	typedef struct packed {
		logic          rd_en;
		logic [AW-1:0] rd_addr;
		logic          wr_en;
		logic [AW-1:0] wr_addr;
		logic [VW-1:0] wr_data;
	} mem_req_t;

endpackage

[design/palist_req_if.sv]
// request channel of the list engine: valid, ready and the operation fields
// depends on palist_pkg
`timescale 1ns / 1ps

interface palist_req_if import palist_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [KW-1:0]        kind;
	logic [PW-1:0]        position;
	logic signed [VW-1:0] value;

	modport source (output valid, output kind, output position, output value, input ready);
	modport sink (input valid, input kind, input position, input value, output ready);
endinterface

[design/palist_rsp_if.sv]
// result channel of the list engine: valid, ready and the result fields
// depends on palist_pkg
`timescale 1ns / 1ps

interface palist_rsp_if import palist_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [SW-1:0]        status;
	logic signed [VW-1:0] read_value;
	logic [FW-1:0]        found_position;
	logic [NCW-1:0]       count;
	logic                 last;

	modport source (output valid, output status, output read_value, output found_position,
		output count, output last, input ready);
	modport sink (input valid, input status, input read_value, input found_position,
		input count, input last, output ready);
endinterface

[design/palist_mem.sv]
// entry store: one write port and one registered read port
// depends on palist_pkg
`timescale 1ns / 1ps

module palist_mem import palist_pkg::*; (
	input  logic          clk,
	input  mem_req_t      mreq,
	output logic [VW-1:0] rdata
);

	logic [VW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			mem[mreq.wr_addr] <= mreq.wr_data;
		end
		if (mreq.rd_en) begin
			rdata <= mem[mreq.rd_addr];
		end
	end

endmodule

[design/palist_ctrl.sv]
// sequencer of the list engine: checks, shift walks, search scan, result register
// depends on palist_pkg, palist_req_if, palist_rsp_if
`timescale 1ns / 1ps

module palist_ctrl import palist_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	palist_req_if.sink    req,
	palist_rsp_if.source  rsp,
	output mem_req_t      mreq,
	input  logic [VW-1:0] rdata
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INS  = 3'd1;
	localparam logic [2:0] S_DEL  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_RDW  = 3'd4;
	localparam logic [2:0] S_SRD  = 3'd5;
	localparam logic [2:0] S_SCMP = 3'd6;
	localparam logic [2:0] S_RESP = 3'd7;

	logic [2:0]     state_q;
	logic [LW-1:0]  len_q;
	logic           pend_s1;
	logic           hit_q;
	logic [NW-1:0]  nfound_q;
	logic           ov_q;

	logic [PW-1:0]  pos_q;
	logic [VW-1:0]  val_q;
	logic [LW-1:0]  idx_q;
	logic [AW-1:0]  waddr_s1;
	logic [FW-1:0]  hit_pos_q;
	logic [SW-1:0]  res_status_q;
	logic [VW-1:0]  res_rv_q;
	logic [FW-1:0]  res_fpos_q;
	logic [SW-1:0]  o_status_q;
	logic [VW-1:0]  o_rv_q;
	logic [FW-1:0]  o_fpos_q;
	logic [NCW-1:0] o_count_q;
	logic           o_last_q;

	logic           accept;
	logic           out_free;
	logic           out_load;
	logic           is_err;
	logic [SW-1:0]  err_status;
	logic [PW-1:0]  in_pos_m1;
	logic [PW-1:0]  pos_m1;
	logic [LW-1:0]  idx_m1;
	logic [LW-1:0]  idx_p1;
	logic           ins_go;
	logic           del_go;
	logic           srch_go;
	logic           match;
	logic           scmp_adv;

	assign accept    = req.valid && req.ready;
	assign out_free  = !ov_q || rsp.ready;
	assign in_pos_m1 = req.position - PW'(1);
	assign pos_m1    = pos_q - PW'(1);
	assign idx_m1    = idx_q - LW'(1);
	assign idx_p1    = idx_q + LW'(1);
	assign ins_go    = CW'(idx_q) >= CW'(pos_q);
	assign del_go    = (CW'(idx_q) + CW'(1)) < CW'(len_q);
	assign srch_go   = (idx_q < len_q) && (NW'(MAX_RESULTS) > nfound_q);
	assign match     = rdata == val_q;
	assign scmp_adv  = !match || !hit_q || out_free;
	assign out_load  = ((state_q == S_RESP) && out_free) ||
		((state_q == S_SCMP) && match && hit_q && out_free);

	// argument checks against the current length
	always_comb begin
		is_err     = 1'b0;
		err_status = ST_OK;
		case (req.kind)
			K_INSERT: begin
				if (len_q == LW'(DEPTH)) begin
					is_err     = 1'b1;
					err_status = ST_FULL;
				end else if (req.position == '0 ||
					CW'(req.position) > CW'(len_q) + CW'(1)) begin
					is_err     = 1'b1;
					err_status = ST_BADPOS;
				end
			end
			K_DELETE: begin
				if (req.position == '0 || CW'(req.position) > CW'(len_q)) begin
					is_err     = 1'b1;
					err_status = ST_BADPOS;
				end
			end
			K_READ: begin
				if (len_q == '0) begin
					is_err     = 1'b1;
					err_status = ST_EMPTY;
				end else if (req.position == '0 || CW'(req.position) > CW'(len_q)) begin
					is_err     = 1'b1;
					err_status = ST_BADPOS;
				end
			end
			K_SEARCH: begin
				if (len_q == '0) begin
					is_err     = 1'b1;
					err_status = ST_EMPTY;
				end
			end
			default: begin
				is_err     = 1'b0;
				err_status = ST_OK;
			end
		endcase
	end

	// memory traffic
	always_comb begin
		mreq = '0;
		case (state_q)
			S_INS: begin
				mreq.wr_en   = pend_s1;
				mreq.wr_addr = waddr_s1;
				mreq.wr_data = rdata;
				if (ins_go) begin
					mreq.rd_en   = 1'b1;
					mreq.rd_addr = AW'(idx_m1);
				end else if (!pend_s1) begin
					// shifting done, drop the new value into its slot
					mreq.wr_en   = 1'b1;
					mreq.wr_addr = AW'(pos_m1);
					mreq.wr_data = val_q;
				end
			end
			S_DEL: begin
				mreq.wr_en   = pend_s1;
				mreq.wr_addr = waddr_s1;
				mreq.wr_data = rdata;
				if (del_go) begin
					mreq.rd_en   = 1'b1;
					mreq.rd_addr = AW'(idx_p1);
				end
			end
			S_RD: begin
				mreq.rd_en   = 1'b1;
				mreq.rd_addr = AW'(pos_m1);
			end
			S_SRD: begin
				mreq.rd_en   = srch_go;
				mreq.rd_addr = AW'(idx_q);
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			len_q    <= '0;
			pend_s1  <= 1'b0;
			hit_q    <= 1'b0;
			nfound_q <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					pend_s1  <= 1'b0;
					hit_q    <= 1'b0;
					nfound_q <= '0;
					if (accept) begin
						if (is_err) begin
							state_q <= S_RESP;
						end else begin
							case (req.kind)
								K_INSERT: state_q <= S_INS;
								K_DELETE: state_q <= S_DEL;
								K_READ:   state_q <= S_RD;
								default:  state_q <= S_SRD;
							endcase
						end
					end
				end
				S_INS: begin
					pend_s1 <= ins_go;
					if (!ins_go && !pend_s1) begin
						len_q   <= len_q + LW'(1);
						state_q <= S_RESP;
					end
				end
				S_DEL: begin
					pend_s1 <= del_go;
					if (!del_go && !pend_s1) begin
						len_q   <= len_q - LW'(1);
						state_q <= S_RESP;
					end
				end
				S_RD: begin
					state_q <= S_RDW;
				end
				S_RDW: begin
					state_q <= S_RESP;
				end
				S_SRD: begin
					state_q <= srch_go ? S_SCMP : S_RESP;
				end
				S_SCMP: begin
					if (scmp_adv) begin
						state_q <= S_SRD;
						if (match) begin
							hit_q    <= 1'b1;
							nfound_q <= nfound_q + NW'(1);
						end
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					pos_q        <= req.position;
					val_q        <= req.value;
					res_status_q <= is_err ? err_status : ST_OK;
					res_rv_q     <= '0;
					res_fpos_q   <= '0;
					case (req.kind)
						K_INSERT: idx_q <= len_q;
						K_DELETE: idx_q <= LW'(in_pos_m1);
						default:  idx_q <= '0;
					endcase
				end
			end
			S_INS: begin
				if (ins_go) begin
					waddr_s1 <= AW'(idx_q);
					idx_q    <= idx_m1;
				end
			end
			S_DEL: begin
				if (del_go) begin
					waddr_s1 <= AW'(idx_q);
					idx_q    <= idx_p1;
				end
			end
			S_RDW: begin
				res_rv_q <= rdata;
			end
			S_SRD: begin
				if (!srch_go) begin
					res_status_q <= hit_q ? ST_OK : ST_NOTFOUND;
					res_fpos_q   <= hit_q ? hit_pos_q : '0;
				end
			end
			S_SCMP: begin
				if (scmp_adv) begin
					idx_q <= idx_p1;
					if (match) begin
						hit_pos_q <= FW'(idx_q) + FW'(1);
					end
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			// a held match goes out without the last mark when a newer one replaces it
			o_status_q <= (state_q == S_RESP) ? res_status_q : ST_OK;
			o_rv_q     <= (state_q == S_RESP) ? res_rv_q : '0;
			o_fpos_q   <= (state_q == S_RESP) ? res_fpos_q : hit_pos_q;
			o_count_q  <= NCW'(len_q);
			o_last_q   <= state_q == S_RESP;
		end
	end

	assign req.ready          = state_q == S_IDLE;
	assign rsp.valid          = ov_q;
	assign rsp.status         = o_status_q;
	assign rsp.read_value     = o_rv_q;
	assign rsp.found_position = o_fpos_q;
	assign rsp.count          = o_count_q;
	assign rsp.last           = o_last_q;

endmodule

[design/positional_array_list_engine.sv]
// top level of the positional array list engine: sequencer plus entry store
// depends on palist_pkg, palist_req_if, palist_rsp_if, palist_mem, palist_ctrl
`timescale 1ns / 1ps

// The engine keeps an ordered list of up to DEPTH (32) signed 32-bit values in one
// synchronous memory with a registered read port and handles one request at a time:
// insert at a 1-based position, delete at a position, read at a position, or search
// for a value. Each request yields one result, except a search, which yields one
// result per matching position in ascending order (at most MAX_RESULTS), with last
// set on the final one, or a single empty or not-found result. Errors leave the list
// as it was. An insert moves each entry from the tail down to its position up one
// slot, then writes the new value (an append moves none); a delete moves each entry
// behind its position down one slot; a read registers the entry it reads; a rejected
// request goes straight to its result. The shift walk moves one entry per cycle
// through the memory's read and write ports. A search reads and then compares each
// stored entry in turn, and stalls on a match while its result register is full.
// A new request is taken as soon as the previous one has loaded its final result into
// the output register, even if that result is still waiting to be taken.

module positional_array_list_engine import palist_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	palist_req_if.sink   req,
	palist_rsp_if.source rsp
);

	mem_req_t      mreq;
	logic [VW-1:0] rdata;

	// sequencer: argument checks, shift walks, search scan and result register
	palist_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.mreq   (mreq),
		.rdata  (rdata)
	);

	// entry store
	palist_mem u_mem (
		.clk   (clk),
		.mreq  (mreq),
		.rdata (rdata)
	);

	// a shift walk never reads the entry it writes in the same cycle
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.rd_en && mreq.wr_en |-> mreq.rd_addr != mreq.wr_addr)
		else $error("memory read and write hit the same entry");

	// the reported length never exceeds the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.count <= NCW'(DEPTH))
		else $error("count above capacity");

	// a result without the last mark is always a search match
	a_mid_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.last |-> rsp.status == ST_OK && rsp.found_position != '0)
		else $error("intermediate result is not a search match");

	// a request in work blocks the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while the previous one is in work");

endmodule
